@@ rtl/core/tu32_pkg.sv @@
package tu32_pkg;

  typedef enum logic [3:0] {
    PhDone     = 4'd0,
    PhSkip     = 4'd1,
    PhZero     = 4'd2,
    PhHexFirst = 4'd3,
    PhHex      = 4'd4,
    PhOct      = 4'd5,
    PhBinFirst = 4'd6,
    PhBin      = 4'd7,
    PhDec      = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StNone = 2'd1,
    StOvf  = 2'd2
  } status_e;

  // bytes at or beyond this index act as the terminator
  localparam logic [15:0] MaxTextLen = 16'd255;

  // largest decimal accumulator that can still take another digit
  localparam logic [31:0] DecLimit = 32'd429496729;
  localparam logic [7:0]  DecLastDigitMax = 8'h35;

  localparam logic [31:0] OvfValue = 32'hffff_ffff;
  localparam logic [7:0]  PosMax   = 8'd255;

endpackage

@@ rtl/core/text_to_uint32_multibase_core.sv @@
// Streaming unsigned 32-bit number parser. Bytes of a text arrive one word per
// cycle; text_start_i marks the first byte of a new text. Leading bytes 1..32 are
// skipped, then 0x/0X selects hex, 0 followed by 0-7 octal, b/B binary, a lone 0
// reads as zero, 1-9 starts decimal, and any other byte shows there is no number.
// At most one result word is issued per text, with the byte that ends the number
// (status 0), or that shows there is no number (status 1), or the digit that would
// overflow 32 bits (status 2, value all-ones); later bytes are swallowed until the
// next text start. A byte passes the input register, its word the result register;
// one byte is taken every cycle while the result side does not stall; a stalled
// result register holds the input register, which holds the input.
module text_to_uint32_multibase_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        text_start_i,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [1:0]  status_o,
  output logic [7:0]  next_position_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic       text_start_q;
  logic [7:0] symbol_q;

  // parse state
  tu32_pkg::phase_e phase_q, phase_d, phase_eff;
  logic [31:0]      acc_q, acc_d;
  logic [7:0]       pos_q, pos_d, pos_eff, idx;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [31:0]       value_q;
  tu32_pkg::status_e status_q;
  logic [7:0]        next_pos_q;

  logic              proc_en;
  logic              res_valid;
  logic [31:0]       res_value;
  tu32_pkg::status_e res_status;
  logic [7:0]        res_pos;

  logic [7:0] c_eff;
  logic       is_space, is_zero_ch, is_b, is_x, is_dec, is_oct, is_bin, is_hex;
  logic [3:0] hex_val;

  assign proc_en    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc_en;
  assign in_valid_d = in_stall_o ? in_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      text_start_q <= text_start_i;
      symbol_q     <= symbol_i;
    end
  end

  // a text start restarts the parse on this very byte
  assign phase_eff = text_start_q ? tu32_pkg::PhSkip : phase_q;
  assign pos_eff   = text_start_q ? 8'd0 : pos_q;
  assign idx       = pos_eff;
  assign c_eff     = ({8'd0, idx} >= tu32_pkg::MaxTextLen) ? 8'd0 : symbol_q;

  assign is_space   = (c_eff >= 8'd1) && (c_eff <= 8'd32);
  assign is_zero_ch = (c_eff == 8'h30);
  assign is_b       = (c_eff == 8'h62) || (c_eff == 8'h42);
  assign is_x       = (c_eff == 8'h78) || (c_eff == 8'h58);
  assign is_dec     = (c_eff >= 8'h30) && (c_eff <= 8'h39);
  assign is_oct     = (c_eff >= 8'h30) && (c_eff <= 8'h37);
  assign is_bin     = (c_eff == 8'h30) || (c_eff == 8'h31);

  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (is_dec) begin
      hex_val = c_eff[3:0];
    end else if ((c_eff >= 8'h41 && c_eff <= 8'h46) || (c_eff >= 8'h61 && c_eff <= 8'h66)) begin
      // letters a-f and A-F share their low three bits: 1..6
      hex_val = 4'd9 + {1'b0, c_eff[2:0]};
    end else begin
      is_hex = 1'b0;
    end
  end

  // result decision
  always_comb begin
    res_valid  = 1'b0;
    res_value  = '0;
    res_status = tu32_pkg::StOk;
    res_pos    = '0;
    unique case (phase_eff)
      tu32_pkg::PhSkip: begin
        if (!is_space && !is_zero_ch && !is_b && !is_dec) begin
          res_valid  = 1'b1;
          res_status = tu32_pkg::StNone;
        end
      end
      tu32_pkg::PhZero: begin
        if (!is_x && !is_oct) begin
          res_valid = 1'b1;
          res_pos   = idx;
        end
      end
      tu32_pkg::PhHexFirst: begin
        if (!is_hex) begin
          res_valid  = 1'b1;
          res_status = tu32_pkg::StNone;
        end
      end
      tu32_pkg::PhHex: begin
        if (!is_hex) begin
          res_valid = 1'b1;
          res_value = acc_q;
          res_pos   = idx;
        end else if (acc_q[31:28] != 4'd0) begin
          res_valid  = 1'b1;
          res_value  = tu32_pkg::OvfValue;
          res_status = tu32_pkg::StOvf;
        end
      end
      tu32_pkg::PhOct: begin
        if (!is_oct) begin
          res_valid = 1'b1;
          res_value = acc_q;
          res_pos   = idx;
        end else if (acc_q[31:29] != 3'd0) begin
          res_valid  = 1'b1;
          res_value  = tu32_pkg::OvfValue;
          res_status = tu32_pkg::StOvf;
        end
      end
      tu32_pkg::PhBinFirst: begin
        if (!is_bin) begin
          res_valid  = 1'b1;
          res_status = tu32_pkg::StNone;
        end
      end
      tu32_pkg::PhBin: begin
        if (!is_bin) begin
          res_valid = 1'b1;
          res_value = acc_q;
          res_pos   = idx;
        end else if (acc_q[31]) begin
          res_valid  = 1'b1;
          res_value  = tu32_pkg::OvfValue;
          res_status = tu32_pkg::StOvf;
        end
      end
      tu32_pkg::PhDec: begin
        if (!is_dec) begin
          res_valid = 1'b1;
          res_value = acc_q;
          res_pos   = idx;
        end else if ((acc_q > tu32_pkg::DecLimit) ||
                     ((acc_q == tu32_pkg::DecLimit) && (c_eff > tu32_pkg::DecLastDigitMax))) begin
          res_valid  = 1'b1;
          res_value  = tu32_pkg::OvfValue;
          res_status = tu32_pkg::StOvf;
        end
      end
      default: begin
      end
    endcase
  end

  // next parse state
  always_comb begin
    phase_d = phase_eff;
    acc_d   = acc_q;
    unique case (phase_eff)
      tu32_pkg::PhSkip: begin
        if (is_zero_ch) begin
          phase_d = tu32_pkg::PhZero;
        end else if (is_b) begin
          phase_d = tu32_pkg::PhBinFirst;
        end else if (is_dec) begin
          phase_d = tu32_pkg::PhDec;
          acc_d   = {28'd0, c_eff[3:0]};
        end
      end
      tu32_pkg::PhZero: begin
        if (is_x) begin
          phase_d = tu32_pkg::PhHexFirst;
        end else if (is_oct) begin
          phase_d = tu32_pkg::PhOct;
          acc_d   = {29'd0, c_eff[2:0]};
        end
      end
      tu32_pkg::PhHexFirst: begin
        phase_d = tu32_pkg::PhHex;
        acc_d   = {28'd0, hex_val};
      end
      tu32_pkg::PhHex: begin
        acc_d = {acc_q[27:0], hex_val};
      end
      tu32_pkg::PhOct: begin
        acc_d = {acc_q[28:0], c_eff[2:0]};
      end
      tu32_pkg::PhBinFirst: begin
        phase_d = tu32_pkg::PhBin;
        acc_d   = {31'd0, c_eff[0]};
      end
      tu32_pkg::PhBin: begin
        acc_d = {acc_q[30:0], c_eff[0]};
      end
      tu32_pkg::PhDec: begin
        // times ten as x8 + x2
        acc_d = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} + {28'd0, c_eff[3:0]};
      end
      default: begin
        phase_d = tu32_pkg::PhDone;
      end
    endcase
    if (res_valid) begin
      phase_d = tu32_pkg::PhDone;
    end
  end

  always_comb begin
    pos_d = pos_eff;
    if (phase_eff != tu32_pkg::PhDone && pos_eff != tu32_pkg::PosMax) begin
      pos_d = pos_eff + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tu32_pkg::PhDone;
      acc_q   <= '0;
      pos_q   <= '0;
    end else if (proc_en) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
    end
  end

  // result register
  assign out_valid_d = (proc_en && res_valid) ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && res_valid) begin
      value_q    <= res_value;
      status_q   <= res_status;
      next_pos_q <= res_pos;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign value_o         = value_q;
  assign status_o        = status_q;
  assign next_position_o = next_pos_q;

  a_ovf_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tu32_pkg::StOvf) |->
      (value_o == tu32_pkg::OvfValue) && (next_position_o == 8'd0))
    else $error("overflow word carries wrong value or position");

  a_none_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tu32_pkg::StNone) |->
      (value_o == 32'd0) && (next_position_o == 8'd0))
    else $error("no-number word carries nonzero fields");

  a_done_after_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_en && res_valid |=> (phase_q == tu32_pkg::PhDone) && out_valid_o)
    else $error("parse not closed after result");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned LongHoldAt     = 30;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned TailCycles     = 20;
  localparam int unsigned MinItems       = 1200;
  localparam int unsigned MaxReported    = 100;

  typedef struct packed {
    logic [31:0]       value;
    tu32_pkg::status_e status;
    logic [7:0]        pos;
  } number_t;

  typedef struct {
    bit          start;
    logic [7:0]  sym;
    int unsigned gap;
    bit          drain;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        text_start = 1'b0;
  logic [7:0]  symbol = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value;
  logic [1:0]  status;
  logic [7:0]  next_pos;

  byte_item_t  pending[$];
  number_t     expected_numbers[$];

  int unsigned errors = 0;
  int unsigned n_predicted = 0;
  int unsigned n_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned tx_wait = 0;
  bit          tx_armed = 1'b0;
  int unsigned rx_wait = 0;
  int unsigned rx_words = 0;

  // stimulus builder state
  bit          gen_first = 1'b0;
  bit          gen_drain = 1'b0;
  int unsigned text_count = 0;

  // predictor state
  tu32_pkg::phase_e parse_ph = tu32_pkg::PhDone;
  logic [31:0]      parse_acc = '0;
  logic [7:0]       parse_pos = '0;

  text_to_uint32_multibase_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .text_start_i    (text_start),
    .symbol_i        (symbol),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .value_o         (value),
    .status_o        (status),
    .next_position_o (next_pos)
  );

  always #5 clk = ~clk;

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  // advances the parse by one byte; returns 1 when this byte yields a number word
  function automatic bit predict_parse(input bit start, input logic [7:0] sym,
                                       output number_t res);
    logic [7:0]        c;
    logic [7:0]        idx;
    int                h;
    bit                got;
    logic [31:0]       v;
    tu32_pkg::status_e st;
    logic [7:0]        p;
    c = sym;
    got = 1'b0;
    v = '0;
    st = tu32_pkg::StOk;
    p = '0;
    res.value = '0;
    res.status = tu32_pkg::StOk;
    res.pos = '0;
    if (start) begin
      parse_ph = tu32_pkg::PhSkip;
      parse_acc = '0;
      parse_pos = '0;
    end
    if (parse_ph == tu32_pkg::PhDone) return 1'b0;
    idx = parse_pos;
    if (parse_pos != tu32_pkg::PosMax) parse_pos++;
    // past the length bound every byte reads as the terminator
    if (16'(idx) >= tu32_pkg::MaxTextLen) c = 8'h00;
    case (parse_ph)
      tu32_pkg::PhSkip: begin
        if (c >= 8'd1 && c <= 8'd32) begin
        end else if (c == "0") begin
          parse_ph = tu32_pkg::PhZero;
        end else if (c == "b" || c == "B") begin
          parse_ph = tu32_pkg::PhBinFirst;
        end else if (c >= "1" && c <= "9") begin
          parse_acc = 32'(c - "0");
          parse_ph = tu32_pkg::PhDec;
        end else begin
          got = 1'b1; st = tu32_pkg::StNone;
        end
      end
      tu32_pkg::PhZero: begin
        if (c == "x" || c == "X") begin
          parse_ph = tu32_pkg::PhHexFirst;
        end else if (c >= "0" && c <= "7") begin
          parse_acc = 32'(c - "0");
          parse_ph = tu32_pkg::PhOct;
        end else begin
          got = 1'b1; p = idx;
        end
      end
      tu32_pkg::PhHexFirst: begin
        h = hex_digit(c);
        if (h < 0) begin
          got = 1'b1; st = tu32_pkg::StNone;
        end else begin
          parse_acc = 32'(h);
          parse_ph = tu32_pkg::PhHex;
        end
      end
      tu32_pkg::PhHex: begin
        h = hex_digit(c);
        if (h < 0) begin
          got = 1'b1; v = parse_acc; p = idx;
        end else if (parse_acc[31:28] != 4'd0) begin
          got = 1'b1; v = tu32_pkg::OvfValue; st = tu32_pkg::StOvf;
        end else begin
          parse_acc = (parse_acc << 4) + 32'(h);
        end
      end
      tu32_pkg::PhOct: begin
        if (c < "0" || c > "7") begin
          got = 1'b1; v = parse_acc; p = idx;
        end else if (parse_acc[31:29] != 3'd0) begin
          got = 1'b1; v = tu32_pkg::OvfValue; st = tu32_pkg::StOvf;
        end else begin
          parse_acc = (parse_acc << 3) + 32'(c - "0");
        end
      end
      tu32_pkg::PhBinFirst: begin
        if (c != "0" && c != "1") begin
          got = 1'b1; st = tu32_pkg::StNone;
        end else begin
          parse_acc = 32'(c - "0");
          parse_ph = tu32_pkg::PhBin;
        end
      end
      tu32_pkg::PhBin: begin
        if (c != "0" && c != "1") begin
          got = 1'b1; v = parse_acc; p = idx;
        end else if (parse_acc[31]) begin
          got = 1'b1; v = tu32_pkg::OvfValue; st = tu32_pkg::StOvf;
        end else begin
          parse_acc = {parse_acc[30:0], c[0]};
        end
      end
      tu32_pkg::PhDec: begin
        if (c < "0" || c > "9") begin
          got = 1'b1; v = parse_acc; p = idx;
        end else if (parse_acc > tu32_pkg::DecLimit ||
                     (parse_acc == tu32_pkg::DecLimit && c > tu32_pkg::DecLastDigitMax)) begin
          got = 1'b1; v = tu32_pkg::OvfValue; st = tu32_pkg::StOvf;
        end else begin
          parse_acc = parse_acc * 32'd10 + 32'(c - "0");
        end
      end
      default: parse_ph = tu32_pkg::PhDone;
    endcase
    if (got) begin
      parse_ph = tu32_pkg::PhDone;
      res.value = v;
      res.status = st;
      res.pos = p;
    end
    return got;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (errors < MaxReported)
      $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    errors++;
  endtask

  task automatic add_byte(logic [7:0] s);
    byte_item_t it;
    it.start = gen_first;
    it.sym = s;
    it.drain = gen_first && gen_drain;
    // every fourth stretch of 100 bytes runs without gaps
    if ((pending.size() / 100) % 4 == 0 || $urandom_range(0, 1) == 0) it.gap = 0;
    else it.gap = $urandom_range(1, 19);
    pending.push_back(it);
    gen_first = 1'b0;
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic new_text();
    gen_first = 1'b1;
    gen_drain = (text_count % 25 == 24);
    text_count++;
  endtask

  task automatic add_digits(int base, int n);
    int d;
    for (int i = 0; i < n; i++) begin
      d = $urandom_range(0, base - 1);
      if (d < 10) add_byte(8'(d) + "0");
      else add_byte(8'(d - 10) + ($urandom_range(0, 1) ? "a" : "A"));
    end
  endtask

  task automatic add_end();
    string punct;
    punct = " ,;)\n";
    case ($urandom_range(0, 2))
      0: add_byte(8'h00);
      1: add_byte(punct[$urandom_range(0, 4)]);
      default: add_byte(8'($urandom_range(0, 255)));
    endcase
    // trailing bytes are swallowed once the word is out
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_long_text(int variant);
    new_text();
    case (variant)
      0: begin
        repeat ($urandom_range(240, 260)) add_byte(" ");
        add_byte(8'($urandom_range(1, 9)) + "0");
        add_digits(10, $urandom_range(0, 15));
      end
      1: repeat ($urandom_range(250, 270)) add_byte("0");
      default: begin
        add_str($urandom_range(0, 1) ? "0x" : "b");
        repeat ($urandom_range(250, 270)) add_byte("0");
      end
    endcase
    add_end();
  endtask

  task automatic add_random_text();
    int kind;
    kind = $urandom_range(0, 19);
    if (text_count % 40 == 10) begin
      add_long_text($urandom_range(0, 2));
      return;
    end
    new_text();
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3))
      add_byte(8'($urandom_range(1, 32)));
    if (kind <= 4) begin
      case ($urandom_range(0, 3))
        0: begin
          add_str("429496729");
          add_digits(10, $urandom_range(1, 2));
        end
        1: begin
          add_str($sformatf("%0d", $urandom() | 32'h1));
          add_digits(10, $urandom_range(0, 1));
        end
        default: begin
          add_byte(8'($urandom_range(1, 9)) + "0");
          add_digits(10, $urandom_range(0, 8));
        end
      endcase
      add_end();
    end else if (kind <= 8) begin
      add_str($urandom_range(0, 1) ? "0x" : "0X");
      add_digits(16, $urandom_range(0, 10));
      add_end();
    end else if (kind <= 11) begin
      add_byte("0");
      add_digits(8, $urandom_range(1, 12));
      add_end();
    end else if (kind <= 14) begin
      add_byte($urandom_range(0, 1) ? "b" : "B");
      add_digits(2, $urandom_range(0, 34));
      add_end();
    end else if (kind == 15) begin
      add_byte("0");
      add_end();
    end else if (kind == 16) begin
      add_byte(8'($urandom_range(0, 255)));
      add_end();
    end else if (kind == 17) begin
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)));
    end else begin
      // left open: the next text start drops it
      add_byte(8'($urandom_range(1, 9)) + "0");
      add_digits(10, $urandom_range(0, 4));
    end
  endtask

  // sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      text_start <= 1'b0;
      symbol <= '0;
      tx_wait = 0;
      tx_armed = 1'b0;
    end else begin : drive
      number_t res;
      bit      free;
      free = !in_valid || !in_stall;
      if (in_valid && !in_stall) begin
        if (predict_parse(text_start, symbol, res)) begin
          expected_numbers.push_back(res);
          n_predicted++;
        end
        void'(pending.pop_front());
      end
      if (free) begin
        if (pending.size() != 0 && !tx_armed) begin
          tx_wait = pending[0].gap;
          tx_armed = 1'b1;
        end
        if (tx_armed && tx_wait == 0 && (!pending[0].drain || n_seen >= n_predicted)) begin
          in_valid <= 1'b1;
          text_start <= pending[0].start;
          symbol <= pending[0].sym;
          tx_armed = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (tx_armed && tx_wait != 0) tx_wait--;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
      rx_words = 0;
    end else begin
      if (out_valid && !out_stall) begin
        rx_words++;
        if (rx_words == LongHoldAt) rx_wait = LongHoldCycles;
        else if ((rx_words / 40) % 3 == 0 || $urandom_range(0, 1) == 0) rx_wait = 0;
        else rx_wait = $urandom_range(1, 19);
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  // result checker
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      n_seen <= 0;
    end else if (out_valid && !out_stall) begin : check
      number_t want;
      n_seen <= n_seen + 1;
      if (expected_numbers.size() == 0) begin
        report_mismatch("word with none expected", value, '0);
      end else begin
        want = expected_numbers.pop_front();
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (status !== want.status) report_mismatch("status", 32'(status), 32'(want.status));
        if (next_pos !== want.pos) report_mismatch("next position", 32'(next_pos), 32'(want.pos));
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // bytes with no text open are ignored
    add_str("A");
    new_text(); add_str(" 7"); add_byte(8'h00);
    new_text(); add_str("0xfF"); add_byte(8'hff);
    new_text(); add_str("07:");
    new_text(); add_str("B10b");
    new_text(); add_str("09");
    new_text(); add_str("0x"); add_byte(8'h00);
    new_text(); add_str("b ");
    new_text(); add_byte(8'h80);
    new_text(); add_str("12");
    new_text(); add_str("5"); add_byte(8'h00);
    new_text(); add_str("4294967295"); add_byte(8'h00);
    while (pending.size() < MinItems) add_random_text();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending.size() == 0 && !in_valid && expected_numbers.size() == 0);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && expected_numbers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
